// ----- rtl/core/rtpdsf_pkg.sv -----
// rtpdsf_pkg: shared constants and types of the rtp duplicate sequence filter
package rtpdsf_pkg;

  // fifo storage
  localparam int DEPTH = 1024;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;

  // field widths
  localparam int SEQ_W  = 16;
  localparam int TS_W   = 32;
  localparam int CAP_W  = 11;
  localparam int HOLD_W = 16;
  localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  // configuration port
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD     = 1'd1;
  localparam logic [CAP_W-1:0]  CAPACITY_RESET = 11'd1024;
  localparam logic [HOLD_W-1:0] HOLD_RESET     = 16'd1500;

  // presence map held as rows of bits
  localparam int MAP_BIT_W  = 4;
  localparam int MAP_ROW_W  = 1 << MAP_BIT_W;
  localparam int MAP_ADDR_W = SEQ_W - MAP_BIT_W;
  localparam int MAP_ROWS   = 1 << MAP_ADDR_W;

  typedef struct packed {
    logic [SEQ_W-1:0] seq;
    logic [TS_W-1:0]  stamp;
  } ring_entry_t;

  localparam int RING_W = $bits(ring_entry_t);

endpackage

// ----- rtl/core/rtpdsf_ram.sv -----
// rtpdsf_ram: generic single write, single read ram with registered read data
module rtpdsf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/rtp_duplicate_sequence_filter_unit.sv -----
// rtp_duplicate_sequence_filter_unit: top level of the rtp duplicate sequence filter
//
//  channel  direction  signals                                  transaction
//  in       sink       in_valid/in_ready, func, seq_num,        one packet to check or record
//                      timestamp_ms
//  out      source     out_valid/out_ready, is_duplicate        one verdict per packet
//  cfg      sink       cfg_we, cfg_index, cfg_wdata             one register write
//
// a packet found in the presence map in check mode goes from lookup straight
// to the verdict; any other packet also passes eviction, one presence map
// read-modify-write per evicted entry, and the append with its own update.
// after reset a clearing pass writes the 4096 rows of the presence map,
// with in_ready low; configuration writes are taken throughout.
// a finished verdict waits in the output register while the next packet is
// accepted and looked up; the sequencer only stalls when handing its verdict
// to a still occupied output register.
module rtp_duplicate_sequence_filter_unit (
  input  logic                                   clk,
  input  logic                                   rst,
  // configuration
  input  logic                                   cfg_we,
  input  logic [rtpdsf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rtpdsf_pkg::CFG_W-1:0]           cfg_wdata,
  // packet input
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   func,
  input  logic [rtpdsf_pkg::SEQ_W-1:0]           seq_num,
  input  logic [rtpdsf_pkg::TS_W-1:0]            timestamp_ms,
  // verdict output
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic                                   is_duplicate
);

  // sequencer state codes
  localparam logic [2:0] S_CLR  = 3'd0;  // clearing pass over the map
  localparam logic [2:0] S_IDLE = 3'd1;  // waiting for a packet
  localparam logic [2:0] S_LOOK = 3'd2;  // presence row back, check mode verdict
  localparam logic [2:0] S_EVAL = 3'd3;  // oldest entry back, decide eviction
  localparam logic [2:0] S_POPW = 3'd4;  // write back row with evicted bit cleared
  localparam logic [2:0] S_APP  = 3'd5;  // append to fifo, read row of new seq
  localparam logic [2:0] S_SET  = 3'd6;  // write back row with new bit set
  localparam logic [2:0] S_OUT  = 3'd7;  // hand verdict to output register

  logic [2:0] state;
  logic [2:0] state_next;

  // configuration registers
  logic [rtpdsf_pkg::CAP_W-1:0]  capacity;
  logic [rtpdsf_pkg::HOLD_W-1:0] hold_time_ms;

  // fifo bookkeeping
  logic [rtpdsf_pkg::IDX_W-1:0] head_ptr;
  logic [rtpdsf_pkg::CNT_W-1:0] entry_count;
  logic [rtpdsf_pkg::MAP_ADDR_W-1:0] clr_addr;

  // packet being worked on
  logic                          cur_func;
  logic [rtpdsf_pkg::SEQ_W-1:0]  cur_seq;
  logic [rtpdsf_pkg::TS_W-1:0]   cur_time;
  logic [rtpdsf_pkg::SEQ_W-1:0]  pop_seq;
  logic                          dup;

  // memory ports
  logic                              map_we;
  logic [rtpdsf_pkg::MAP_ADDR_W-1:0] map_waddr;
  logic [rtpdsf_pkg::MAP_ROW_W-1:0]  map_wdata;
  logic                              map_re;
  logic [rtpdsf_pkg::MAP_ADDR_W-1:0] map_raddr;
  logic [rtpdsf_pkg::MAP_ROW_W-1:0]  map_rdata;

  logic                          ring_we;
  logic [rtpdsf_pkg::IDX_W-1:0]  ring_waddr;
  rtpdsf_pkg::ring_entry_t       ring_wdata;
  logic                          ring_re;
  logic [rtpdsf_pkg::IDX_W-1:0]  ring_raddr;
  rtpdsf_pkg::ring_entry_t       ring_rdata;

  // derived values
  logic [rtpdsf_pkg::IDX_W-1:0]  head_inc;
  logic [rtpdsf_pkg::SUM_W-1:0]  tail_sum;
  logic [rtpdsf_pkg::IDX_W-1:0]  tail_ptr;
  logic [rtpdsf_pkg::CMP_W-1:0]  cap_ext;
  logic [rtpdsf_pkg::CMP_W-1:0]  cap_eff;
  logic [rtpdsf_pkg::CMP_W-1:0]  count_ext;
  logic [rtpdsf_pkg::TS_W-1:0]   age;
  logic                          pop;
  logic                          out_free;
  logic [rtpdsf_pkg::MAP_ROW_W-1:0] cur_mask;
  logic [rtpdsf_pkg::MAP_ROW_W-1:0] pop_mask;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  // fifo pointers wrap at the storage depth
  assign head_inc = (head_ptr == rtpdsf_pkg::IDX_W'(rtpdsf_pkg::DEPTH - 1)) ?
                    '0 : head_ptr + 1'b1;
  assign tail_sum = rtpdsf_pkg::SUM_W'(head_ptr) + rtpdsf_pkg::SUM_W'(entry_count);
  assign tail_ptr = (tail_sum >= rtpdsf_pkg::SUM_W'(rtpdsf_pkg::DEPTH)) ?
                    rtpdsf_pkg::IDX_W'(tail_sum - rtpdsf_pkg::SUM_W'(rtpdsf_pkg::DEPTH)) :
                    rtpdsf_pkg::IDX_W'(tail_sum);

  // capacity saturates at the storage depth
  assign cap_ext   = rtpdsf_pkg::CMP_W'(capacity);
  assign cap_eff   = (cap_ext > rtpdsf_pkg::CMP_W'(rtpdsf_pkg::DEPTH)) ?
                     rtpdsf_pkg::CMP_W'(rtpdsf_pkg::DEPTH) : cap_ext;
  assign count_ext = rtpdsf_pkg::CMP_W'(entry_count);

  // age of the oldest entry, wrapping modulo 2^32
  assign age = cur_time - ring_rdata.stamp;
  assign pop = (entry_count != '0) &&
               ((count_ext >= cap_eff) ||
                (age > rtpdsf_pkg::TS_W'(hold_time_ms)));

  assign cur_mask = rtpdsf_pkg::MAP_ROW_W'(1) << cur_seq[rtpdsf_pkg::MAP_BIT_W-1:0];
  assign pop_mask = rtpdsf_pkg::MAP_ROW_W'(1) << pop_seq[rtpdsf_pkg::MAP_BIT_W-1:0];

  // memory port control
  always_comb begin
    map_we     = 1'b0;
    map_waddr  = cur_seq[rtpdsf_pkg::SEQ_W-1:rtpdsf_pkg::MAP_BIT_W];
    map_wdata  = map_rdata | cur_mask;
    map_re     = 1'b0;
    map_raddr  = seq_num[rtpdsf_pkg::SEQ_W-1:rtpdsf_pkg::MAP_BIT_W];
    ring_we    = 1'b0;
    ring_waddr = tail_ptr;
    ring_wdata = '{seq: cur_seq, stamp: cur_time};
    ring_re    = 1'b0;
    ring_raddr = head_ptr;
    case (state)
      S_CLR: begin
        map_we    = 1'b1;
        map_waddr = clr_addr;
        map_wdata = '0;
      end
      S_IDLE: begin
        // presence row of the new packet and the oldest fifo entry
        map_re  = in_valid;
        ring_re = in_valid;
      end
      S_EVAL: begin
        if (pop) begin
          map_re     = 1'b1;
          map_raddr  = ring_rdata.seq[rtpdsf_pkg::SEQ_W-1:rtpdsf_pkg::MAP_BIT_W];
          ring_re    = 1'b1;
          ring_raddr = head_inc;
        end
      end
      S_POPW: begin
        map_we    = 1'b1;
        map_waddr = pop_seq[rtpdsf_pkg::SEQ_W-1:rtpdsf_pkg::MAP_BIT_W];
        map_wdata = map_rdata & ~pop_mask;
      end
      S_APP: begin
        // row is re-read as evictions may have changed it
        ring_we   = 1'b1;
        map_re    = 1'b1;
        map_raddr = cur_seq[rtpdsf_pkg::SEQ_W-1:rtpdsf_pkg::MAP_BIT_W];
      end
      S_SET: begin
        map_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_CLR: begin
        if (clr_addr == rtpdsf_pkg::MAP_ADDR_W'(rtpdsf_pkg::MAP_ROWS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        if (!cur_func && ((map_rdata & cur_mask) != '0)) begin
          state_next = S_OUT;
        end else begin
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        state_next = pop ? S_POPW : S_APP;
      end
      S_POPW: state_next = S_EVAL;
      S_APP:  state_next = S_SET;
      S_SET:  state_next = S_OUT;
      S_OUT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLR;
      clr_addr     <= '0;
      head_ptr     <= '0;
      entry_count  <= '0;
      capacity     <= rtpdsf_pkg::CAPACITY_RESET;
      hold_time_ms <= rtpdsf_pkg::HOLD_RESET;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          rtpdsf_pkg::REG_CAPACITY: capacity     <= cfg_wdata[rtpdsf_pkg::CAP_W-1:0];
          rtpdsf_pkg::REG_HOLD:     hold_time_ms <= cfg_wdata[rtpdsf_pkg::HOLD_W-1:0];
          default: begin
          end
        endcase
      end
      if (state == S_CLR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (state == S_EVAL && pop) begin
        head_ptr    <= head_inc;
        entry_count <= entry_count - 1'b1;
      end
      if (state == S_SET) begin
        entry_count <= entry_count + 1'b1;
      end
      if (state == S_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      cur_func <= func;
      cur_seq  <= seq_num;
      cur_time <= timestamp_ms;
      dup      <= 1'b0;
    end
    if (state == S_LOOK && !cur_func && ((map_rdata & cur_mask) != '0)) begin
      dup <= 1'b1;
    end
    if (state == S_EVAL) begin
      pop_seq <= ring_rdata.seq;
    end
    if (state == S_OUT && out_free) begin
      is_duplicate <= dup;
    end
  end

  // presence map, one bit per sequence number
  rtpdsf_ram #(
    .WIDTH (rtpdsf_pkg::MAP_ROW_W),
    .DEPTH (rtpdsf_pkg::MAP_ROWS)
  ) u_map_ram (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .re    (map_re),
    .raddr (map_raddr),
    .rdata (map_rdata)
  );

  // fifo of (sequence, time) entries
  rtpdsf_ram #(
    .WIDTH (rtpdsf_pkg::RING_W),
    .DEPTH (rtpdsf_pkg::DEPTH)
  ) u_ring_ram (
    .clk   (clk),
    .we    (ring_we),
    .waddr (ring_waddr),
    .wdata (ring_wdata),
    .re    (ring_re),
    .raddr (ring_raddr),
    .rdata (ring_rdata)
  );

endmodule

// ----- bench/rtp_duplicate_sequence_filter_checker.sv -----
// duplicate filter checker: watches the channels, predicts each verdict and compares
module rtp_duplicate_sequence_filter_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [rtpdsf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rtpdsf_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                             in_valid,
  input  logic                             in_ready,
  input  logic                             func,
  input  logic [rtpdsf_pkg::SEQ_W-1:0]     seq_num,
  input  logic [rtpdsf_pkg::TS_W-1:0]      timestamp_ms,
  input  logic                             out_valid,
  input  logic                             out_ready,
  input  logic                             is_duplicate,
  output int                               mismatch_count,
  output int                               verdicts_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // the block holds at most two packets, so a small ring of verdicts is plenty
  localparam int VERDICT_SLOTS = 16;

  // own copy of the history fifo and presence map
  logic [rtpdsf_pkg::SEQ_W-1:0]  held_seq   [rtpdsf_pkg::DEPTH];
  logic [rtpdsf_pkg::TS_W-1:0]   held_stamp [rtpdsf_pkg::DEPTH];
  int unsigned                   oldest_idx;
  int unsigned                   held_count;
  bit [(1<<rtpdsf_pkg::SEQ_W)-1:0] seen_map;
  logic [rtpdsf_pkg::CAP_W-1:0]  capacity_reg;
  logic [rtpdsf_pkg::HOLD_W-1:0] hold_reg;

  // predicted verdicts in order of acceptance
  bit                      verdict_buf [VERDICT_SLOTS];
  int unsigned             verdict_rd = 0;
  int unsigned             verdict_wr = 0;
  int                      failures = 0;
  int                      open_verdicts = 0;

  assign mismatch_count   = failures;
  assign verdicts_pending = open_verdicts;

  function automatic void drop_oldest();
    seen_map[held_seq[oldest_idx]] = 1'b0;
    oldest_idx = (oldest_idx + 1) % rtpdsf_pkg::DEPTH;
    held_count--;
  endfunction

  // verdict for one packet, updating the history as the filter does
  function automatic bit judge_packet(input logic record_only,
                                      input logic [rtpdsf_pkg::SEQ_W-1:0] s,
                                      input logic [rtpdsf_pkg::TS_W-1:0] now);
    int          limit;
    logic [rtpdsf_pkg::TS_W-1:0] age;
    int unsigned tail;
    if (!record_only && seen_map[s]) return 1'b1;
    limit = (int'(capacity_reg) > rtpdsf_pkg::DEPTH) ? rtpdsf_pkg::DEPTH : int'(capacity_reg);
    while (held_count != 0) begin
      age = now - held_stamp[oldest_idx];
      if (held_count >= limit || age > hold_reg) drop_oldest();
      else break;
    end
    if (held_count >= rtpdsf_pkg::DEPTH) drop_oldest();
    tail = (oldest_idx + held_count) % rtpdsf_pkg::DEPTH;
    held_seq[tail]   = s;
    held_stamp[tail] = now;
    held_count++;
    seen_map[s] = 1'b1;
    return 1'b0;
  endfunction

  always @(posedge clk) begin
    bit want;
    if (rst) begin
      oldest_idx    = 0;
      held_count    = 0;
      seen_map      = '0;
      capacity_reg  = rtpdsf_pkg::CAPACITY_RESET;
      hold_reg      = rtpdsf_pkg::HOLD_RESET;
      verdict_rd    = 0;
      verdict_wr    = 0;
      open_verdicts = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == rtpdsf_pkg::REG_CAPACITY)
          capacity_reg = cfg_wdata[rtpdsf_pkg::CAP_W-1:0];
        else if (cfg_index == rtpdsf_pkg::REG_HOLD)
          hold_reg = cfg_wdata[rtpdsf_pkg::HOLD_W-1:0];
      end
      if (out_valid && out_ready) begin
        if (open_verdicts == 0) begin
          $error("is_duplicate: verdict with nothing outstanding, actual %0b", is_duplicate);
          failures++;
        end else begin
          want = verdict_buf[verdict_rd];
          verdict_rd = (verdict_rd + 1) % VERDICT_SLOTS;
          open_verdicts--;
          if (is_duplicate !== want) begin
            $error("is_duplicate mismatch: expected %0b, actual %0b", want, is_duplicate);
            failures++;
          end
        end
      end
      if (in_valid && in_ready) begin
        if (open_verdicts >= VERDICT_SLOTS) begin
          $error("is_duplicate: more transactions outstanding than the block can hold");
          failures++;
        end else begin
          verdict_buf[verdict_wr] = judge_packet(func, seq_num, timestamp_ms);
          verdict_wr = (verdict_wr + 1) % VERDICT_SLOTS;
          open_verdicts++;
        end
      end
    end
  end

endmodule

// ----- bench/rtp_duplicate_sequence_filter_unit_tb.sv -----
// duplicate filter testbench top: clock, reset, packet and register stimulus, verdict
module rtp_duplicate_sequence_filter_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // generous ceiling, far above the length of the slowest legal run
  localparam int CYCLE_LIMIT     = 500000;
  // receiver back-pressure stretch, long enough to fill the block and stall its input
  localparam int HOLD_OFF_CYCLES = 250;
  // quiet cycles once every verdict is home, before a register write or the end
  localparam int SETTLE_CYCLES   = 16;

  logic                             clk;
  logic                             rst;
  logic                             cfg_we;
  logic [rtpdsf_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [rtpdsf_pkg::CFG_W-1:0]     cfg_wdata;
  logic                             in_valid;
  logic                             in_ready;
  logic                             func;
  logic [rtpdsf_pkg::SEQ_W-1:0]     seq_num;
  logic [rtpdsf_pkg::TS_W-1:0]      timestamp_ms;
  logic                             out_valid;
  logic                             out_ready;
  logic                             is_duplicate;

  int                               mismatch_count;
  int                               verdicts_pending;
  int                               cycle_count = 0;
  int                               send_idle_pct;
  int                               take_idle_pct;
  bit                               hold_off_req;
  logic [rtpdsf_pkg::TS_W-1:0]      clock_ms;

  rtp_duplicate_sequence_filter_unit DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .func         (func),
    .seq_num      (seq_num),
    .timestamp_ms (timestamp_ms),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .is_duplicate (is_duplicate)
  );

  rtp_duplicate_sequence_filter_checker u_checker (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .func             (func),
    .seq_num          (seq_num),
    .timestamp_ms     (timestamp_ms),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .is_duplicate     (is_duplicate),
    .mismatch_count   (mismatch_count),
    .verdicts_pending (verdicts_pending)
  );

  // 12 ns clock, first rising edge at 6 ns
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // watchdog: a hung handshake or a verdict that never arrives ends here
  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  // offer one packet transaction; valid is only dropped when an idle burst comes first,
  // so back-to-back packets keep valid high with no glitch
  task automatic send_packet(input logic f, input logic [rtpdsf_pkg::SEQ_W-1:0] s,
                             input logic [rtpdsf_pkg::TS_W-1:0] t);
    int gap;
    gap = 0;
    if ($urandom_range(0, 99) < send_idle_pct) gap = int'($urandom_range(1, 7));
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    func         <= f;
    seq_num      <= s;
    timestamp_ms <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // stop offering, then wait until every verdict is back and the block has gone quiet
  task automatic settle_filter();
    in_valid <= 1'b0;
    @(negedge clk);
    while (verdicts_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // one register write; the idle step after it keeps consecutive writes in separate steps
  task automatic write_reg(input logic [rtpdsf_pkg::CFG_IDX_W-1:0] idx,
                           input logic [rtpdsf_pkg::CFG_W-1:0] word);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= word;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // one random phase under a given register setting
  //   pool_span  : most sequence numbers come from a narrow window so repeats are common
  //   step_max   : normal forward step of the packet clock
  //   expire_pct : share of packets after a random jump of up to three hold times plus three
  //   noise_pct  : share of packets with a wholly random timestamp
  task automatic run_phase(input logic [rtpdsf_pkg::CFG_W-1:0] cap_word,
                           input logic [rtpdsf_pkg::CFG_W-1:0] hold_word,
                           input int count, input int record_pct, input int pool_span,
                           input int step_max, input int expire_pct, input int noise_pct,
                           input int send_pct, input int take_pct);
    logic [rtpdsf_pkg::SEQ_W-1:0] pool_base;
    logic [rtpdsf_pkg::SEQ_W-1:0] s;
    logic [rtpdsf_pkg::TS_W-1:0]  stamp;
    logic                         f;
    int                           pick;
    write_reg(rtpdsf_pkg::REG_CAPACITY, cap_word);
    write_reg(rtpdsf_pkg::REG_HOLD, hold_word);
    send_idle_pct = send_pct;
    take_idle_pct = take_pct;
    pool_base = rtpdsf_pkg::SEQ_W'($urandom);
    repeat (count) begin
      pick = int'($urandom_range(0, 99));
      if (pick < noise_pct) begin
        stamp = $urandom;
      end else begin
        if (pick < noise_pct + expire_pct)
          clock_ms = clock_ms + $urandom_range(0, 3 * int'(hold_word) + 3);
        else
          clock_ms = clock_ms + $urandom_range(0, step_max);
        stamp = clock_ms;
      end
      if ($urandom_range(0, 99) < 70)
        s = pool_base + rtpdsf_pkg::SEQ_W'($urandom_range(0, pool_span));
      else
        s = rtpdsf_pkg::SEQ_W'($urandom);
      f = ($urandom_range(0, 99) < record_pct);
      send_packet(f, s, stamp);
    end
    settle_filter();
  endtask

  // verdict receiver: random stall bursts, plus one long hold-off on request
  initial begin : verdict_sink
    int stall_left;
    bit long_done;
    stall_left = 0;
    long_done  = 1'b0;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (hold_off_req && !long_done) begin
        // sender keeps going meanwhile, so the block fills and drops in_ready
        long_done  = 1'b1;
        out_ready <= 1'b0;
        stall_left = HOLD_OFF_CYCLES - 1;
      end else if ($urandom_range(0, 99) < take_idle_pct) begin
        out_ready <= 1'b0;
        stall_left = int'($urandom_range(0, 6));
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = rtpdsf_pkg::REG_CAPACITY;
    cfg_wdata     = '0;
    in_valid      = 1'b0;
    func          = 1'b0;
    seq_num       = '0;
    timestamp_ms  = '0;
    send_idle_pct = 30;
    take_idle_pct = 30;
    hold_off_req  = 1'b0;
    clock_ms      = '0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part under reset settings (capacity 1024, hold 1500 ms);
    // first packet waits out the presence map clearing pass
    send_packet(1'b0, 16'h0000, 32'd0);          // new sequence, lowest value
    send_packet(1'b0, 16'h0000, 32'd1);          // same again: duplicate
    send_packet(1'b1, 16'h0000, 32'd2);          // record-only repeat, never a duplicate
    send_packet(1'b0, 16'hFFFF, 32'd3);          // highest sequence
    send_packet(1'b0, 16'hFFFF, 32'd4);
    send_packet(1'b1, 16'hAAAA, 32'hFFFF_FFFF);  // far jump ages everything out
    send_packet(1'b0, 16'h5555, 32'hFFFF_FF00);  // time going back looks very old
    send_packet(1'b0, 16'h1234, 32'h0000_0100);  // age taken across the 32-bit wrap
    send_packet(1'b0, 16'h5555, 32'h0000_0101);  // still held after the wrap
    // repeated sequence in record-only mode: popping the older copy clears the bit
    send_packet(1'b1, 16'd7, 32'd512);
    send_packet(1'b1, 16'd7, 32'd1280);
    send_packet(1'b1, 16'd8, 32'd2100);          // evicts the older copy of 7
    send_packet(1'b0, 16'd7, 32'd2101);          // newer copy still held, bit clear anyway
    send_packet(1'b0, 16'd7, 32'd2102);
    // hold boundary: age equal to the hold time is kept, one more expires
    send_packet(1'b0, 16'd9, 32'd3000);
    send_packet(1'b1, 16'd10, 32'd4500);
    send_packet(1'b0, 16'd9, 32'd4500);
    send_packet(1'b0, 16'd11, 32'd4501);
    send_packet(1'b0, 16'd9, 32'd4501);
    settle_filter();

    clock_ms = $urandom;
    // capacity above the fifo depth, longest hold: the fifo grows with no eviction once older entries age out
    run_phase(16'h07FF, 16'hFFFF, 320, 80, 2047, 1, 0, 0, 0, 10);
    // capacity one (upper data bits ignored), zero hold
    run_phase(16'hF801, 16'h0000, 60, 30, 7, 2, 5, 3, 40, 40);
    // capacity zero: every entry goes before the new one lands
    run_phase(16'h0000, 16'd20, 60, 30, 3, 15, 10, 5, 20, 50);
    // small fifo, with the long receiver hold-off
    hold_off_req = 1'b1;
    run_phase(16'd16, 16'd100, 100, 25, 31, 10, 5, 3, 30, 20);
    // reset values written back explicitly
    run_phase(16'd1024, 16'd1500, 100, 20, 255, 20, 5, 3, 50, 30);
    // packet clock runs across the 32-bit wrap
    clock_ms = 32'hFFFF_F800;
    run_phase(16'd200, 16'd4000, 80, 20, 63, 200, 3, 2, 25, 25);
    // tail with no idling on either side
    run_phase(16'd64, 16'd3000, 60, 20, 31, 30, 5, 2, 0, 0);

    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
